FILE: rtl/hsbq_pkg.sv
package hsbq_pkg;

	localparam int REG_COUNT = 6;
	localparam int REG_IDX_W = 3;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_B0,
		REG_B1,
		REG_B2,
		REG_A1,
		REG_A2,
		REG_NORM
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_MID,
		ST_NORM,
		ST_DONE
	} state_t;

	// control from the sequencer to the coefficient shift registers
	typedef struct packed {
		logic load;
		logic shift_mac;
		logic shift_norm;
	} coef_ctl_t;

	// current serial bit of each coefficient
	typedef struct packed {
		logic b0;
		logic b1;
		logic b2;
		logic a1;
		logic a2;
		logic nr;
	} coef_bits_t;

	// control from the sequencer to the serial accumulator
	typedef struct packed {
		logic clear;
		logic step;
		logic last;
	} mac_ctl_t;

endpackage

FILE: rtl/hsbq_coef_regs.sv
module hsbq_coef_regs #(
	parameter int COEF_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [hsbq_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [COEF_WIDTH-1:0]          cfg_wdata,
	input  hsbq_pkg::coef_ctl_t            ctl,
	output hsbq_pkg::coef_bits_t           bits
);
	import hsbq_pkg::*;

	localparam logic [COEF_WIDTH-1:0] ONE = COEF_WIDTH'(1) << (COEF_WIDTH - 8);

	logic [COEF_WIDTH-1:0] b0_q, b1_q, b2_q, a1_q, a2_q, nr_q;
	logic [COEF_WIDTH-1:0] b0_sr_q, b1_sr_q, b2_sr_q, a1_sr_q, a2_sr_q, nr_sr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b0_q <= ONE;
			b1_q <= '0;
			b2_q <= '0;
			a1_q <= '0;
			a2_q <= '0;
			nr_q <= ONE;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_B0:   b0_q <= cfg_wdata;
				REG_B1:   b1_q <= cfg_wdata;
				REG_B2:   b2_q <= cfg_wdata;
				REG_A1:   a1_q <= cfg_wdata;
				REG_A2:   a2_q <= cfg_wdata;
				REG_NORM: nr_q <= cfg_wdata;
				default:  ;
			endcase
		end
	end

	// copy on accept, then present one bit per cycle, LSB first
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			b0_sr_q <= b0_q;
			b1_sr_q <= b1_q;
			b2_sr_q <= b2_q;
			a1_sr_q <= a1_q;
			a2_sr_q <= a2_q;
			nr_sr_q <= nr_q;
		end else begin
			if (ctl.shift_mac) begin
				b0_sr_q <= b0_sr_q >> 1;
				b1_sr_q <= b1_sr_q >> 1;
				b2_sr_q <= b2_sr_q >> 1;
				a1_sr_q <= a1_sr_q >> 1;
				a2_sr_q <= a2_sr_q >> 1;
			end
			if (ctl.shift_norm) begin
				nr_sr_q <= nr_sr_q >> 1;
			end
		end
	end

	assign bits = '{b0: b0_sr_q[0], b1: b1_sr_q[0], b2: b2_sr_q[0],
		a1: a1_sr_q[0], a2: a2_sr_q[0], nr: nr_sr_q[0]};

endmodule

FILE: rtl/hsbq_serial_mac.sv
module hsbq_serial_mac #(
	parameter int PP_W = 34,
	parameter int LO_W = 32
) (
	input  logic                          clk,
	input  hsbq_pkg::mac_ctl_t            ctl,
	input  logic signed [PP_W-1:0]        pp,
	output logic signed [PP_W+LO_W-1:0]   prod
);
	import hsbq_pkg::*;

	logic signed [PP_W-1:0] hi_q;
	logic [LO_W-1:0]        lo_q;
	logic signed [PP_W-1:0] sum;

	// the multiplier MSB carries negative weight: subtract on the last bit
	always_comb begin
		sum = ctl.last ? (hi_q - pp) : (hi_q + pp);
	end

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			hi_q <= '0;
			lo_q <= '0;
		end else if (ctl.step) begin
			hi_q <= sum >>> 1;
			lo_q <= {sum[0], lo_q[LO_W-1:1]};
		end
	end

	assign prod = {hi_q, lo_q};

endmodule

FILE: rtl/high_shelf_biquad_filter_top.sv
// Samples are taken one at a time: a new sample is accepted only after the previous result
// has been handed to the output register. Each coefficient is consumed one bit per cycle by
// a bit-serial shift-add accumulator, first for the five-tap sum, then for the normalizer
// product, with states for accept, mid rounding and output handoff, which waits on a stall.
// Reset: asynchronous, active low; coefficients return to pass-through (b0 = norm = 1.0,
// others 0), histories clear, output empty. A valid register write also clears histories.
module high_shelf_biquad_filter_top #(
	parameter int SAMPLE_WIDTH = 24,
	parameter int COEF_WIDTH   = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      s_tdata,  // [SW-1:0] in_sample
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      m_tdata,  // [SW-1:0] out_sample
	input  logic                                   cfg_we,
	input  logic [hsbq_pkg::REG_IDX_W-1:0]         cfg_index,
	input  logic [COEF_WIDTH-1:0]                  cfg_wdata
);
	import hsbq_pkg::*;

	localparam int DATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
	localparam int MID_W  = SAMPLE_WIDTH + 8;
	localparam int PP_W   = SAMPLE_WIDTH + 10;
	localparam int ACC_W  = PP_W + COEF_WIDTH;
	localparam int FRAC   = COEF_WIDTH - 8;
	localparam int CNT_W  = $clog2(COEF_WIDTH);

	localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(1) << (FRAC - 1);
	localparam logic signed [ACC_W-1:0] MID_HI = (ACC_W'(1) << (MID_W - 1)) - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] MID_LO = ~MID_HI;
	localparam logic signed [ACC_W-1:0] OUT_HI = (ACC_W'(1) << (SAMPLE_WIDTH - 1)) - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] OUT_LO = ~OUT_HI;
	localparam logic [CNT_W-1:0]        CNT_LAST = CNT_W'(COEF_WIDTH - 1);

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;

	logic signed [SAMPLE_WIDTH-1:0] x_q, x1_q, x2_q, y1_q, y2_q;
	logic signed [MID_W-1:0]        mid_q;
	logic [SAMPLE_WIDTH-1:0]        out_q;
	logic                           out_vld_q;

	coef_ctl_t  coef_ctl;
	coef_bits_t cbits;
	mac_ctl_t   mac_ctl;

	logic signed [PP_W-1:0]  pp;
	logic signed [ACC_W-1:0] prod;
	logic signed [ACC_W-1:0] rnd;
	logic signed [MID_W-1:0] mid_sat;
	logic signed [SAMPLE_WIDTH-1:0] y_sat;

	logic in_acc, out_free, hist_clr, cnt_last;

	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !out_vld_q || m_tready;
	assign hist_clr = cfg_we && (cfg_index < REG_IDX_W'(REG_COUNT));
	assign cnt_last = (cnt_q == CNT_LAST);

	hsbq_coef_regs #(
		.COEF_WIDTH(COEF_WIDTH)
	) u_coef (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.ctl      (coef_ctl),
		.bits     (cbits)
	);

	hsbq_serial_mac #(
		.PP_W(PP_W),
		.LO_W(COEF_WIDTH)
	) u_mac (
		.clk (clk),
		.ctl (mac_ctl),
		.pp  (pp),
		.prod(prod)
	);

	// partial product for the current coefficient bit
	always_comb begin
		pp = '0;
		if (state_q == ST_MAC) begin
			if (cbits.b0) pp = pp + PP_W'(x_q);
			if (cbits.b1) pp = pp + PP_W'(x1_q);
			if (cbits.b2) pp = pp + PP_W'(x2_q);
			if (cbits.a1) pp = pp - PP_W'(y1_q);
			if (cbits.a2) pp = pp - PP_W'(y2_q);
		end else if (cbits.nr) begin
			pp = PP_W'(mid_q);
		end
	end

	// round half up, then saturate to the intermediate and the sample width
	always_comb begin
		rnd = (prod + HALF) >>> FRAC;
		if (rnd > MID_HI)      mid_sat = MID_HI[MID_W-1:0];
		else if (rnd < MID_LO) mid_sat = MID_LO[MID_W-1:0];
		else                   mid_sat = rnd[MID_W-1:0];
		if (rnd > OUT_HI)      y_sat = OUT_HI[SAMPLE_WIDTH-1:0];
		else if (rnd < OUT_LO) y_sat = OUT_LO[SAMPLE_WIDTH-1:0];
		else                   y_sat = rnd[SAMPLE_WIDTH-1:0];
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		coef_ctl = '0;
		mac_ctl  = '0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					coef_ctl.load = 1'b1;
					mac_ctl.clear = 1'b1;
					state_d       = ST_MAC;
				end
			end
			ST_MAC: begin
				coef_ctl.shift_mac = 1'b1;
				mac_ctl.step       = 1'b1;
				mac_ctl.last       = cnt_last;
				if (cnt_last) state_d = ST_MID;
			end
			ST_MID: begin
				mac_ctl.clear = 1'b1;
				state_d       = ST_NORM;
			end
			ST_NORM: begin
				coef_ctl.shift_norm = 1'b1;
				mac_ctl.step        = 1'b1;
				mac_ctl.last        = cnt_last;
				if (cnt_last) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			out_vld_q <= 1'b0;
			x1_q      <= '0;
			x2_q      <= '0;
			y1_q      <= '0;
			y2_q      <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_MAC || state_q == ST_NORM) cnt_q <= cnt_q + CNT_W'(1);
			else                                         cnt_q <= '0;

			if (state_q == ST_DONE && out_free) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end

			if (hist_clr) begin
				x1_q <= '0;
				x2_q <= '0;
				y1_q <= '0;
				y2_q <= '0;
			end else if (state_q == ST_DONE && out_free) begin
				// advance the histories
				x2_q <= x1_q;
				x1_q <= x_q;
				y2_q <= y1_q;
				y1_q <= y_sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) x_q <= s_tdata[SAMPLE_WIDTH-1:0];
		if (state_q == ST_MID) mid_q <= mid_sat;
		if (state_q == ST_DONE && out_free) out_q <= y_sat;
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = DATA_W'(out_q);

endmodule

FILE: rtl/hsbq_checker.sv
module hsbq_checker #(
	parameter int SAMPLE_WIDTH = 24
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [((SAMPLE_WIDTH+7)/8)*8-1:0] m_tdata
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output changed while stalled");

	// one sample at a time: busy right after a transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted back to back");

	// a result appears only at the end of a busy period
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result without a sample in flight");

	// returning to idle always delivers a result
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(s_tready) |-> m_tvalid)
		else $error("sample finished without a result");

endmodule

bind high_shelf_biquad_filter_top hsbq_checker #(
	.SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_hsbq_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

FILE: test/high_shelf_biquad_filter_top_tb.sv
module high_shelf_biquad_filter_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import hsbq_pkg::*;

	localparam int  SW           = 24;
	localparam int  CW           = 32;
	localparam int  DW           = ((SW + 7) / 8) * 8;
	localparam int  FRAC         = CW - 8;
	localparam real CLK_PERIOD   = 12.0;
	localparam int  RESET_CYCLES = 7;
	localparam int  LATENCY      = CW * 2 + 3;
	localparam int  QUIET_LIMIT  = 3000;
	localparam int  PHASES       = 4;
	localparam int  GROUPS       = 4;
	localparam int  GROUP_LEN    = 40;

	localparam logic [REG_IDX_W-1:0] IDX_SPARE_LO = REG_IDX_W'(REG_COUNT);
	localparam logic [REG_IDX_W-1:0] IDX_SPARE_HI = '1;

	localparam logic [SW-1:0] SMP_MAX  = {1'b0, {(SW - 1){1'b1}}};
	localparam logic [SW-1:0] SMP_MIN  = {1'b1, {(SW - 1){1'b0}}};
	localparam logic [CW-1:0] COEF_MAX = {1'b0, {(CW - 1){1'b1}}};
	localparam logic [CW-1:0] COEF_MIN = {1'b1, {(CW - 1){1'b0}}};
	localparam logic [CW-1:0] COEF_ONE = CW'(1) << FRAC;
	localparam longint        UNITY    = longint'(1) <<< FRAC;
	localparam longint        HALF_LSB = longint'(1) <<< (FRAC - 1);

	typedef enum bit {ROW_WRITE, ROW_SAMPLE} row_kind_t;

	typedef struct {
		row_kind_t              kind;
		logic [REG_IDX_W-1:0]   idx;
		logic [CW-1:0]          val;
		logic [SW-1:0]          smp;
		bit                     typed;
		logic [SW-1:0]          typed_out;
	} stim_row_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [DW-1:0]        s_tdata   = '0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [DW-1:0]        m_tdata;
	logic                 cfg_we    = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [CW-1:0]        cfg_wdata = '0;

	// shelf filter state as the block should hold it
	longint coef_q [REG_COUNT] = '{UNITY, 0, 0, 0, 0, UNITY};
	longint x_d1 = 0;
	longint x_d2 = 0;
	longint y_d1 = 0;
	longint y_d2 = 0;

	logic [SW-1:0] filtered_due [$];
	stim_row_t     directed_rows [$];

	int src_idle_pct = 0;
	int snk_stall_pct = 0;
	int quiet_cycles = 0;
	int n_samples = 0;
	int n_checked = 0;
	int n_writes = 0;
	int n_errors = 0;

	int src_idle_by_phase [PHASES] = '{0, 61, 0, 36};
	int snk_stall_by_phase [PHASES] = '{0, 0, 61, 36};

	high_shelf_biquad_filter_top #(
		.SAMPLE_WIDTH(SW),
		.COEF_WIDTH  (CW)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic longint clamp_to(longint v, int w);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (w - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	// a write to a real register replaces it and empties all four histories
	function automatic void apply_reg(logic [REG_IDX_W-1:0] idx, logic [CW-1:0] val);
		if (idx < REG_COUNT) begin
			coef_q[idx] = longint'($signed(val));
			x_d1 = 0;
			x_d2 = 0;
			y_d1 = 0;
			y_d2 = 0;
		end
	endfunction

	function automatic logic [SW-1:0] filter_sample(logic [SW-1:0] smp);
		longint x;
		longint acc;
		longint mid;
		longint y;
		x = longint'($signed(smp));
		acc = x * coef_q[REG_B0] + x_d1 * coef_q[REG_B1] + x_d2 * coef_q[REG_B2]
			- y_d1 * coef_q[REG_A1] - y_d2 * coef_q[REG_A2];
		mid = clamp_to((acc + HALF_LSB) >>> FRAC, SW + 8);
		y = clamp_to((mid * coef_q[REG_NORM] + HALF_LSB) >>> FRAC, SW);
		x_d2 = x_d1;
		x_d1 = x;
		y_d2 = y_d1;
		y_d1 = y;
		return y[SW-1:0];
	endfunction

	function automatic void add_write(logic [REG_IDX_W-1:0] idx, logic [CW-1:0] val);
		directed_rows.push_back('{ROW_WRITE, idx, val, '0, 1'b0, '0});
	endfunction

	function automatic void add_sample(logic [SW-1:0] smp, bit typed, logic [SW-1:0] typed_out);
		directed_rows.push_back('{ROW_SAMPLE, '0, '0, smp, typed, typed_out});
	endfunction

	function automatic logic [CW-1:0] pick_coef(logic [REG_IDX_W-1:0] idx);
		int span;
		span = (idx == REG_A2) ? (1 << FRAC) - 1 : 1 << (FRAC + 1);
		case ($urandom_range(9))
			0: return COEF_MAX;
			1: return COEF_MIN;
			2: return '0;
			3, 4: return CW'($urandom);
			default: begin
				// usable filter: norm in [0.25, 1.5], taps within +-2, a2 within +-1
				if (idx == REG_NORM) return CW'($urandom_range(3 << (FRAC - 1), 1 << (FRAC - 2)));
				return CW'(int'($urandom_range(2 * span)) - span);
			end
		endcase
	endfunction

	function automatic logic [SW-1:0] pick_sample();
		case ($urandom_range(9))
			0: return SMP_MAX;
			1: return SMP_MIN;
			2, 3, 4: return SW'(int'($urandom_range(1 << 21)) - (1 << 20));
			default: return SW'($urandom);
		endcase
	endfunction

	task automatic send_sample(logic [SW-1:0] smp, bit typed, logic [SW-1:0] typed_out);
		logic [SW-1:0] predicted;
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= DW'(smp);
		do @(posedge clk); while (!s_tready);
		predicted = filter_sample(smp);
		filtered_due.push_back(typed ? typed_out : predicted);
		n_samples++;
	endtask

	// drain every pending result before touching the registers
	task automatic settle();
		s_tvalid <= 1'b0;
		while (filtered_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CW-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		apply_reg(idx, val);
		n_writes++;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	always @(posedge clk) begin : out_check
		logic [SW-1:0] due;
		if (arst_n && m_tvalid && m_tready) begin
			if (filtered_due.size() == 0) begin
				$display("%0t: out_sample %h with no transaction pending", $time,
					m_tdata[SW-1:0]);
				n_errors++;
			end else begin
				due = filtered_due.pop_front();
				n_checked++;
				if (m_tdata[SW-1:0] !== due) begin
					$display("%0t: out_sample mismatch, expected %h, got %h", $time, due,
						m_tdata[SW-1:0]);
					n_errors++;
				end
			end
		end
		m_tready <= ($urandom_range(99) >= snk_stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
			$display("high_shelf_biquad_filter_top_tb NOT OK");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		// pass-through after reset
		add_sample('0, 1'b1, '0);
		add_sample(SMP_MAX, 1'b1, SMP_MAX);
		add_sample(SMP_MIN, 1'b1, SMP_MIN);
		add_sample('1, 1'b1, '1);
		add_sample(SW'(1), 1'b1, SW'(1));
		add_sample(24'h555555, 1'b1, 24'h555555);
		add_sample(24'hAAAAAA, 1'b1, 24'hAAAAAA);
		// largest and most negative gain saturate the output
		add_write(REG_B0, COEF_MAX);
		add_sample(SMP_MAX, 1'b1, SMP_MAX);
		add_sample(SMP_MIN, 1'b1, SMP_MIN);
		add_write(REG_B0, COEF_MIN);
		add_sample(SMP_MAX, 1'b1, SMP_MIN);
		add_sample(SMP_MIN, 1'b1, SMP_MAX);
		// overflow the tap sum so the normalizer input clips
		add_write(REG_B0, COEF_MAX);
		add_write(REG_B1, COEF_MAX);
		add_write(REG_B2, COEF_MAX);
		add_write(REG_NORM, CW'(1));
		add_sample(SMP_MAX, 1'b0, '0);
		add_sample(SMP_MAX, 1'b0, '0);
		add_sample(SMP_MAX, 1'b0, '0);
		// spare indexes must leave coefficients and histories alone
		add_write(IDX_SPARE_LO, '1);
		add_sample(SMP_MAX, 1'b0, '0);
		add_write(IDX_SPARE_HI, COEF_MIN);
		// feedback at the extremes with a negative normalizer
		add_write(REG_B1, '0);
		add_write(REG_B2, '0);
		add_write(REG_A1, COEF_MIN);
		add_write(REG_A2, COEF_MAX);
		add_write(REG_NORM, COEF_MIN);
		add_sample(24'h400000, 1'b0, '0);
		add_sample(24'hC00000, 1'b0, '0);
		add_sample('0, 1'b0, '0);
		add_sample(SMP_MAX, 1'b0, '0);
		add_write(REG_NORM, COEF_MAX);
		add_sample(24'h123456, 1'b0, '0);
		add_sample(SMP_MIN, 1'b0, '0);
		add_sample(SMP_MAX, 1'b0, '0);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				settle();
				write_reg(directed_rows[i].idx, directed_rows[i].val);
			end else begin
				send_sample(directed_rows[i].smp, directed_rows[i].typed,
					directed_rows[i].typed_out);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			src_idle_pct = src_idle_by_phase[ph];
			snk_stall_pct = snk_stall_by_phase[ph];
			for (int g = 0; g < GROUPS; g++) begin
				settle();
				if ($urandom_range(5) == 0) begin
					for (int r = 0; r < REG_COUNT; r++)
						write_reg(REG_IDX_W'(r),
							(r == REG_B0 || r == REG_NORM) ? COEF_ONE : '0);
				end else begin
					for (int r = 0; r < REG_COUNT; r++)
						if ($urandom_range(3) != 0)
							write_reg(REG_IDX_W'(r), pick_coef(REG_IDX_W'(r)));
				end
				if ($urandom_range(3) == 0)
					write_reg($urandom_range(1) ? IDX_SPARE_LO : IDX_SPARE_HI, CW'($urandom));
				for (int k = 0; k < GROUP_LEN; k++) send_sample(pick_sample(), 1'b0, '0);
			end
		end

		s_tvalid <= 1'b0;
		while (filtered_due.size() != 0) @(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);

		$display("Sent %0d samples, checked %0d outputs, made %0d register writes",
			n_samples, n_checked, n_writes);
		$display("Covered pass-through, clipping, spare indexes and random filters under four idle mixes");
		if (n_errors == 0) begin
			$display("high_shelf_biquad_filter_top_tb OK");
		end else begin
			$display("high_shelf_biquad_filter_top_tb NOT OK");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/hsbq_pkg.sv
rtl/hsbq_coef_regs.sv
rtl/hsbq_serial_mac.sv
rtl/high_shelf_biquad_filter_top.sv
rtl/hsbq_checker.sv
test/high_shelf_biquad_filter_top_tb.sv
